// ===== src/assert_macros.svh =====
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== src/otsu_hc_pkg.sv =====
// Types and constants of the Otsu histogram cutoff block.
`timescale 1ns / 1ps
package otsu_hc_pkg;
	localparam int BIN_W  = 24;
	localparam int NPIX_W = 24;
	localparam int CUT_W  = 9;
	localparam logic signed [CUT_W-1:0] CUT_NONE = -9'sd1;

	typedef enum logic [3:0] {
		ST_LOAD,
		ST_RD,
		ST_ACC,
		ST_CHK,
		ST_MSTART,
		ST_MRUN,
		ST_MDONE,
		ST_NEXT,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_X,
		OP_Y,
		OP_SQ,
		OP_DEN,
		OP_L,
		OP_R
	} mul_op_t;

	typedef enum logic [1:0] {
		SGN_NEG  = 2'd0,
		SGN_ZERO = 2'd1,
		SGN_POS  = 2'd2
	} sign_t;
endpackage

// ===== src/otsu_hc_bin_if.sv =====
// Input channel: one histogram bin count per beat.
`timescale 1ns / 1ps
interface otsu_hc_bin_if import otsu_hc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [BIN_W-1:0] bin_count;
	logic             last_bin;

	modport source(output valid, bin_count, last_bin, input ready);
	modport sink(input valid, bin_count, last_bin, output ready);
endinterface

// ===== src/otsu_hc_cut_if.sv =====
// Output channel: chosen cutoff and overflow flag per beat.
`timescale 1ns / 1ps
interface otsu_hc_cut_if import otsu_hc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [CUT_W-1:0] cutoff;
	logic                    overflow;

	modport source(output valid, cutoff, overflow, input ready);
	modport sink(input valid, cutoff, overflow, output ready);
endinterface

// ===== src/otsu_histogram_cutoff_core.sv =====
// Otsu histogram cutoff: bin store, weighted sums and shift-add scan sequencer.
// Load: one bin beat per cycle; the last beat starts the scan, or the output for a single bin.
// Scan: per bin the states RD, ACC, CHK and NEXT, plus none, four or six products on a shared
// shift-add multiplier (start, run, done states) of BW bits (BW = 75 at default widths).
// No beat is accepted from the last beat until the result is presented.
// arst_n clears control, load sum and bin count; total_pixels resets to 1; the store is kept.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module otsu_histogram_cutoff_core import otsu_hc_pkg::*; #(
	parameter int MAX_BINS   = 256,
	parameter int COUNT_BITS = 24
) (
	input  logic              clk,
	input  logic              arst_n,
	otsu_hc_bin_if.sink       bin_in,
	otsu_hc_cut_if.source     cut_out,
	input  logic              total_pixels_we,
	input  logic [NPIX_W-1:0] total_pixels_wdata
);
	localparam int CW   = (COUNT_BITS < BIN_W) ? COUNT_BITS : BIN_W;
	localparam int IB   = $clog2(MAX_BINS + 1);
	localparam int AB   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
	localparam int WB   = CW + IB;
	localparam int MB   = CW + 2 * IB;
	localparam int GB   = (WB > NPIX_W) ? WB : NPIX_W;
	localparam int XB   = MB + GB;
	localparam int DB   = WB + GB;
	localparam int AW   = 2 * XB;
	localparam int BW   = (XB > DB) ? XB : DB;
	localparam int PW   = AW + BW;
	localparam int CNTW = $clog2(BW + 1);
	localparam int PKW  = (AB > CUT_W) ? AB : CUT_W;

	state_t state_q, state_d;
	mul_op_t op_q;

	logic [NPIX_W-1:0] npix_q;
	logic [CW-1:0]     mem [MAX_BINS];
	logic [CW-1:0]     rd_q;
	logic [IB-1:0]     bins_q;
	logic [MB-1:0]     wt_q;
	logic              ovf_q;
	logic [IB-1:0]     last_q;
	logic [IB-1:0]     idx_q;
	logic [WB-1:0]     w_q;
	logic [MB-1:0]     m_q;
	logic [XB-1:0]     x_q;
	logic [XB-1:0]     diff_q;
	sign_t             sgn_q;
	sign_t             best_sgn_q;
	logic [AW-1:0]     sq_q;
	logic [AW-1:0]     best_sq_q;
	logic [DB-1:0]     den_q;
	logic [DB-1:0]     best_den_q;
	logic [PW-1:0]     l_q;
	logic [AB-1:0]     pick_q;
	logic signed [CUT_W-1:0] res_cut_q;
	logic              out_v_q;
	logic signed [CUT_W-1:0] out_cut_q;
	logic              out_ovf_q;

	logic [AW-1:0]   ma_q;
	logic [BW-1:0]   mb_q;
	logic [PW-1:0]   acc_q;
	logic [CNTW-1:0] mcnt_q;

	logic              in_acc;
	logic              full;
	logic [IB-1:0]     loaded_after;
	logic [IB+CW-1:0]  load_prod;
	logic [IB+CW-1:0]  scan_prod;
	logic [IB-1:0]     idx_inc;
	logic [GB-1:0]     w_ext;
	logic [GB-1:0]     n_ext;
	logic [GB-1:0]     gap;
	logic              degen;
	logic              first;
	logic              finish;
	logic              out_free;
	logic [AW-1:0]     opa;
	logic [BW-1:0]     opb;
	logic [XB-1:0]     y_res;
	logic [DB-1:0]     den_res;
	logic [PW-1:0]     r_res;
	logic              den_take;
	logic              den_mul;
	logic              r_take;
	logic [PKW-1:0]    pick_wide;

	assign in_acc       = bin_in.valid && bin_in.ready;
	assign full         = (bins_q == IB'(MAX_BINS));
	assign loaded_after = full ? bins_q : bins_q + IB'(1);
	assign load_prod    = (IB + CW)'(loaded_after) * (IB + CW)'(bin_in.bin_count[CW-1:0]);
	assign idx_inc      = idx_q + IB'(1);
	assign scan_prod    = (IB + CW)'(idx_inc) * (IB + CW)'(rd_q);
	assign w_ext        = GB'(w_q);
	assign n_ext        = GB'(npix_q);
	assign gap          = (n_ext >= w_ext) ? n_ext - w_ext : w_ext - n_ext;
	assign degen        = (w_q == '0) || (w_ext == n_ext);
	assign first        = (idx_q == '0);
	assign finish       = (idx_inc == last_q);
	assign out_free     = !out_v_q || cut_out.ready;
	assign y_res        = acc_q[XB-1:0];
	assign den_res      = acc_q[DB-1:0];
	assign r_res        = acc_q;
	assign den_take     = first || ((sgn_q != best_sgn_q) && (sgn_q > best_sgn_q));
	assign den_mul      = !first && (sgn_q == best_sgn_q) && (sgn_q != SGN_ZERO);
	assign r_take       = (sgn_q == SGN_POS) ? (l_q > r_res) : (l_q < r_res);
	assign pick_wide    = PKW'(pick_q);

	always_comb begin
		opa = '0;
		opb = '0;
		case (op_q)
			OP_X: begin
				opa = AW'(wt_q);
				opb = BW'(w_q);
			end
			OP_Y: begin
				opa = AW'(m_q);
				opb = BW'(npix_q);
			end
			OP_SQ: begin
				opa = AW'(diff_q);
				opb = BW'(diff_q);
			end
			OP_DEN: begin
				opa = AW'(w_q);
				opb = BW'(gap);
			end
			OP_L: begin
				opa = sq_q;
				opb = BW'(best_den_q);
			end
			OP_R: begin
				opa = best_sq_q;
				opb = BW'(den_q);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_acc && bin_in.last_bin) begin
					state_d = (loaded_after <= IB'(1)) ? ST_OUT : ST_RD;
				end
			end
			ST_RD:     state_d = ST_ACC;
			ST_ACC:    state_d = ST_CHK;
			ST_CHK: begin
				if (degen) begin
					state_d = first ? ST_OUT : ST_NEXT;
				end else begin
					state_d = ST_MSTART;
				end
			end
			ST_MSTART: state_d = ST_MRUN;
			ST_MRUN: begin
				if (mcnt_q == CNTW'(1)) begin
					state_d = ST_MDONE;
				end
			end
			ST_MDONE: begin
				case (op_q)
					OP_X, OP_Y, OP_SQ, OP_L: state_d = ST_MSTART;
					OP_DEN:                  state_d = den_mul ? ST_MSTART : ST_NEXT;
					default:                 state_d = ST_NEXT;
				endcase
			end
			ST_NEXT:   state_d = finish ? ST_OUT : ST_RD;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_LOAD;
				end
			end
			default:   state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		bin_in.ready     = (state_q == ST_LOAD);
		cut_out.valid    = out_v_q;
		cut_out.cutoff   = out_cut_q;
		cut_out.overflow = out_ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			npix_q <= NPIX_W'(1);
		end else if (total_pixels_we) begin
			npix_q <= total_pixels_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && !full) begin
			mem[bins_q[AB-1:0]] <= bin_in.bin_count[CW-1:0];
		end
		if (state_q == ST_RD) begin
			rd_q <= mem[idx_q[AB-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bins_q    <= '0;
			wt_q      <= '0;
			ovf_q     <= 1'b0;
			out_v_q   <= 1'b0;
			out_cut_q <= '0;
			out_ovf_q <= 1'b0;
		end else begin
			if (in_acc) begin
				if (!full) begin
					bins_q <= loaded_after;
					wt_q   <= wt_q + MB'(load_prod);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (state_q == ST_OUT && out_free) begin
				out_v_q   <= 1'b1;
				out_cut_q <= res_cut_q;
				out_ovf_q <= ovf_q;
				bins_q    <= '0;
				wt_q      <= '0;
				ovf_q     <= 1'b0;
			end else if (cut_out.valid && cut_out.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_X;
		end else if (state_q == ST_CHK) begin
			op_q <= OP_X;
		end else if (state_q == ST_MDONE) begin
			case (op_q)
				OP_X:    op_q <= OP_Y;
				OP_Y:    op_q <= OP_SQ;
				OP_SQ:   op_q <= OP_DEN;
				OP_DEN:  op_q <= OP_L;
				OP_L:    op_q <= OP_R;
				default: op_q <= OP_X;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				if (in_acc && bin_in.last_bin) begin
					last_q    <= loaded_after - IB'(1);
					idx_q     <= '0;
					w_q       <= '0;
					m_q       <= '0;
					res_cut_q <= CUT_NONE;
				end
			end
			ST_ACC: begin
				w_q <= w_q + WB'(rd_q);
				m_q <= m_q + MB'(scan_prod);
			end
			ST_CHK: begin
				if (degen && first) begin
					res_cut_q <= '0;
				end
			end
			ST_MDONE: begin
				case (op_q)
					OP_X: x_q <= acc_q[XB-1:0];
					OP_Y: begin
						diff_q <= (x_q >= y_res) ? x_q - y_res : y_res - x_q;
						if (x_q == y_res) begin
							sgn_q <= SGN_ZERO;
						end else begin
							sgn_q <= (GB'(npix_q) > w_ext) ? SGN_POS : SGN_NEG;
						end
					end
					OP_SQ: sq_q <= acc_q[AW-1:0];
					OP_DEN: begin
						den_q <= den_res;
						if (den_take) begin
							best_sq_q  <= sq_q;
							best_den_q <= den_res;
							best_sgn_q <= sgn_q;
							pick_q     <= idx_q[AB-1:0];
						end
					end
					OP_L: l_q <= acc_q;
					OP_R: begin
						if (r_take) begin
							best_sq_q  <= sq_q;
							best_den_q <= den_q;
							best_sgn_q <= sgn_q;
							pick_q     <= idx_q[AB-1:0];
						end
					end
					default: begin
						l_q <= l_q;
					end
				endcase
			end
			ST_NEXT: begin
				idx_q <= idx_inc;
				if (finish) begin
					res_cut_q <= pick_wide[CUT_W-1:0];
				end
			end
			default: begin
				idx_q <= idx_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MSTART) begin
			ma_q   <= opa;
			mb_q   <= opb;
			acc_q  <= '0;
			mcnt_q <= CNTW'(BW);
		end else if (state_q == ST_MRUN) begin
			acc_q  <= {acc_q[PW-2:0], 1'b0} + (mb_q[BW-1] ? PW'(ma_q) : '0);
			mb_q   <= {mb_q[BW-2:0], 1'b0};
			mcnt_q <= mcnt_q - CNTW'(1);
		end
	end

	`ASSERT_IMPL(a_mul_start, clk, arst_n, state_q == ST_MSTART |=> state_q == ST_MRUN, "multiplier start not followed by run")
	`ASSERT_NEVER(a_bins_bound, clk, arst_n, bins_q > IB'(MAX_BINS), "bin count beyond store depth")
	`ASSERT_IMPL(a_rd_range, clk, arst_n, state_q == ST_RD |-> idx_q < last_q, "scan read past the last bin")
	`ASSERT_IMPL(a_out_load, clk, arst_n, state_q == ST_OUT && !out_v_q |=> out_v_q && state_q == ST_LOAD, "result not presented")
endmodule
